// ===== sv/welford_ab_trial_compare_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef WELFORD_AB_TRIAL_COMPARE_MACROS_SVH
`define WELFORD_AB_TRIAL_COMPARE_MACROS_SVH
// Overlapping implication, checked every clock outside reset.
`define WAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked every clock outside reset.
`define WAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/wat_pkg.sv =====
// Package: types and constants of the A/B trial comparator.
package wat_pkg;
	localparam int unsigned MAX_TRIALS = 1024;
	localparam logic [10:0] MAX_TRIALS_C = 11'(MAX_TRIALS);
	localparam logic [46:0] VAR_MAX = {47{1'b1}};
	localparam logic [16:0] CONF_ONE = 17'd65536;

	localparam logic [1:0] CFG_TRIAL_COUNT = 2'd0;
	localparam logic [1:0] CFG_MIN_IMPR    = 2'd1;
	localparam logic [1:0] CFG_REQ_CONF    = 2'd2;

	localparam logic [1:0] OUT_INVALID  = 2'd0;
	localparam logic [1:0] OUT_NEUTRAL  = 2'd1;
	localparam logic [1:0] OUT_IMPROVED = 2'd2;
	localparam logic [1:0] OUT_DEGRADED = 2'd3;

	typedef enum logic [1:0] {
		OP_DIV  = 2'd0,
		OP_MUL  = 2'd1,
		OP_SQRT = 2'd2
	} iter_op_t;

	typedef struct packed {
		logic        start;
		iter_op_t    op;
		logic [63:0] a;
		logic [32:0] b;
		logic [6:0]  cnt;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [65:0] prod;
		logic [31:0] root;
	} iter_rsp_t;
endpackage

// ===== sv/wat_iter.sv =====
// Shared iterative unit: restoring divide, shift-add multiply, digit square root.
module wat_iter (
	input  logic              clk,
	input  logic              arst_n,
	input  wat_pkg::iter_req_t req,
	output wat_pkg::iter_rsp_t rsp
);
	import wat_pkg::*;

	logic        busy_q;
	logic        done_q;
	iter_op_t    op_q;
	logic [6:0]  cnt_q;
	logic [63:0] acc_q;
	logic [34:0] rem_q;
	logic [32:0] b_q;
	logic [31:0] root_q;

	logic [34:0] div_rem;
	logic [35:0] div_diff;
	logic [34:0] mul_sum;
	logic [34:0] sq_rem;
	logic [34:0] sq_trial;
	logic [35:0] sq_diff;

	always_comb begin
		div_rem  = {rem_q[33:0], acc_q[63]};
		div_diff = {1'b0, div_rem} - {3'b0, b_q};
		mul_sum  = {1'b0, rem_q[33:0]} + (acc_q[0] ? {2'b0, b_q} : 35'd0);
		sq_rem   = {rem_q[32:0], acc_q[63:62]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_diff  = {1'b0, sq_rem} - {1'b0, sq_trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.cnt;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			acc_q  <= req.a;
			b_q    <= req.b;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				OP_DIV: begin
					if (!div_diff[35]) begin
						rem_q <= div_diff[34:0];
						acc_q <= {acc_q[62:0], 1'b1};
					end else begin
						rem_q <= div_rem;
						acc_q <= {acc_q[62:0], 1'b0};
					end
				end
				OP_MUL: begin
					rem_q <= {1'b0, mul_sum[34:1]};
					acc_q <= {31'b0, mul_sum[0], acc_q[32:1]};
				end
				OP_SQRT: begin
					acc_q <= {acc_q[61:0], 2'b00};
					if (!sq_diff[35]) begin
						rem_q  <= sq_diff[34:0];
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[30:0], 1'b0};
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;
	assign rsp.prod = {rem_q[32:0], acc_q[32:0]};
	assign rsp.root = root_q;
endmodule

// ===== sv/welford_ab_trial_compare.sv =====
// Top level: Welford A/B trial comparator with one shared iterative unit.
// Usage:
//  Samples arrive on in_valid/in_stall with sample_value (Q16.16) and
//  sample_bad. The first trial_count samples form the baseline arm, the next
//  trial_count the candidate arm (0 counts as 1, above 1024 as 1024). After
//  the last candidate sample one result transfer appears on out_valid/out_stall.
//  Each good sample runs a 33-step divide for the mean and a 33-step multiply
//  for M2 through the shared unit; a bad sample skips both. Closing an arm
//  of more than one sample adds a 64-step variance divide; the verdict adds
//  a 64-step noise divide, a 32-step square root and, for a nonzero root, a
//  48-step confidence divide, all on the same unit. in_stall is high while
//  a sample is in work. Configuration writes (cfg_index/cfg_data) are taken
//  every cycle, cfg_ready is always high; write only while the block is idle.
//  Reset clears the sequencer, both arms and the config (trial_count 16).
//  A held result waits in the output register; the block keeps taking samples
//  and only the next verdict waits until the receiver has taken the result.
module welford_ab_trial_compare (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  sample_value,
	input  logic                sample_bad,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          outcome,
	output logic signed [31:0]  improvement,
	output logic [16:0]         confidence_out,
	output logic signed [31:0]  baseline_mean,
	output logic signed [31:0]  candidate_mean,
	output logic [46:0]         baseline_variance,
	output logic [46:0]         candidate_variance,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import wat_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MDIV = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_CHK  = 9'b000001000,
		ST_VDIV = 9'b000010000,
		ST_NDIV = 9'b000100000,
		ST_SQRT = 9'b001000000,
		ST_CDIV = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	iter_req_t req;
	iter_rsp_t rsp;

	logic [10:0] tc_q;
	logic [30:0] mi_q;
	logic [16:0] rc_q;

	logic               phase_q;
	logic [10:0]        idx_q;
	logic signed [31:0] mean_q;
	logic [63:0]        m2_q;
	logic               inv_q;
	logic signed [31:0] bmean_q;
	logic [46:0]        bvar_q;
	logic [46:0]        cvar_q;
	logic signed [31:0] x_q;
	logic [32:0]        ad_q;
	logic               neg_q;
	logic [16:0]        conf_q;

	logic               ov_q;
	logic [1:0]         oc_q;
	logic signed [31:0] oimp_q;
	logic [16:0]        oconf_q;
	logic signed [31:0] obm_q;
	logic signed [31:0] ocm_q;
	logic [46:0]        obv_q;
	logic [46:0]        ocv_q;

	logic [10:0]        n;
	logic [10:0]        eff;
	logic signed [32:0] delta;
	logic [32:0]        ad_in;
	logic signed [33:0] mean_new34;
	logic signed [31:0] mean_new;
	logic signed [32:0] delta2;
	logic [32:0]        ad2;
	logic [64:0]        m2_sum;
	logic [46:0]        var_sat;
	logic signed [32:0] dfull;
	logic signed [31:0] dsat;
	logic [31:0]        dabs;
	logic [16:0]        req_c;
	logic signed [33:0] d34;
	logic signed [33:0] mi34;
	logic [1:0]         verdict;
	logic               accept;
	logic               out_free;

	wat_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		n          = idx_q + 11'd1;
		eff        = (tc_q == 11'd0) ? 11'd1 : ((tc_q > MAX_TRIALS_C) ? MAX_TRIALS_C : tc_q);
		delta      = 33'(sample_value) - 33'(mean_q);
		ad_in      = delta[32] ? 33'(-delta) : delta;
		mean_new34 = neg_q ? (34'(mean_q) - $signed({1'b0, rsp.quo[32:0]}))
		                   : (34'(mean_q) + $signed({1'b0, rsp.quo[32:0]}));
		mean_new   = mean_new34[31:0];
		delta2     = 33'(x_q) - 33'(mean_new);
		ad2        = delta2[32] ? 33'(-delta2) : delta2;
		m2_sum     = {1'b0, m2_q} + {15'b0, rsp.prod[65:16]};
		var_sat    = (rsp.quo[63:47] != '0) ? VAR_MAX : rsp.quo[46:0];
		dfull      = 33'(mean_q) - 33'(bmean_q);
		if (dfull[32] != dfull[31])
			dsat = dfull[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			dsat = dfull[31:0];
		dabs       = dsat[31] ? 32'(-33'(dsat)) : dsat;
		req_c      = (rc_q > CONF_ONE) ? CONF_ONE : rc_q;
		d34        = 34'(dsat);
		mi34       = $signed({3'b0, mi_q});
		if (d34 > mi34 && conf_q >= req_c) verdict = OUT_IMPROVED;
		else if (d34 < -mi34) verdict = OUT_DEGRADED;
		else verdict = OUT_NEUTRAL;
		accept   = in_valid && !in_stall;
		out_free = !ov_q || !out_stall;
	end

	always_comb begin
		req       = '0;
		req.op    = OP_DIV;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !sample_bad) begin
					req.start = 1'b1;
					req.a     = {ad_in, 31'b0};
					req.b     = {22'b0, n};
					req.cnt   = 7'd33;
				end
			end
			ST_MDIV: begin
				if (rsp.done) begin
					req.start = 1'b1;
					req.op    = OP_MUL;
					req.a     = {31'b0, ad_q};
					req.b     = ad2;
					req.cnt   = 7'd33;
				end
			end
			ST_CHK: begin
				if (n >= eff) begin
					if (n > 11'd1) begin
						req.start = 1'b1;
						req.a     = m2_q;
						req.b     = {22'b0, n - 11'd1};
						req.cnt   = 7'd64;
					end else if (phase_q) begin
						req.start = 1'b1;
						req.a     = {1'b0, bvar_q, 16'b0};
						req.b     = {22'b0, n};
						req.cnt   = 7'd64;
					end
				end
			end
			ST_VDIV: begin
				if (rsp.done && phase_q) begin
					req.start = 1'b1;
					req.a     = {({1'b0, bvar_q} + {1'b0, var_sat}), 16'b0};
					req.b     = {22'b0, n};
					req.cnt   = 7'd64;
				end
			end
			ST_NDIV: begin
				if (rsp.done) begin
					req.start = 1'b1;
					req.op    = OP_SQRT;
					req.a     = rsp.quo;
					req.cnt   = 7'd32;
				end
			end
			ST_SQRT: begin
				if (rsp.done && rsp.root != '0) begin
					req.start = 1'b1;
					req.a     = {dabs, 32'b0};
					req.b     = {1'b0, dabs} + {1'b0, rsp.root};
					req.cnt   = 7'd48;
				end
			end
			ST_MUL, ST_CDIV, ST_FIN: req.start = 1'b0;
			default: req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= 11'd16;
			mi_q <= '0;
			rc_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TRIAL_COUNT: tc_q <= cfg_data[10:0];
				CFG_MIN_IMPR:    mi_q <= cfg_data[30:0];
				CFG_REQ_CONF:    rc_q <= cfg_data[16:0];
				default:         tc_q <= tc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			idx_q   <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
			inv_q   <= 1'b0;
			bmean_q <= '0;
			bvar_q  <= '0;
			cvar_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall && state_q != ST_FIN) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q   <= sample_value;
						ad_q  <= ad_in;
						neg_q <= delta[32];
						if (sample_bad) begin
							inv_q   <= 1'b1;
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_MDIV;
						end
					end
				end
				ST_MDIV: begin
					if (rsp.done) begin
						mean_q  <= mean_new;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (rsp.done) begin
						m2_q    <= m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (n < eff) begin
						idx_q   <= n;
						state_q <= ST_IDLE;
					end else if (n > 11'd1) begin
						state_q <= ST_VDIV;
					end else if (!phase_q) begin
						bmean_q <= mean_q;
						bvar_q  <= '0;
						phase_q <= 1'b1;
						idx_q   <= '0;
						mean_q  <= '0;
						m2_q    <= '0;
						state_q <= ST_IDLE;
					end else begin
						cvar_q  <= '0;
						state_q <= ST_NDIV;
					end
				end
				ST_VDIV: begin
					if (rsp.done) begin
						if (!phase_q) begin
							bmean_q <= mean_q;
							bvar_q  <= var_sat;
							phase_q <= 1'b1;
							idx_q   <= '0;
							mean_q  <= '0;
							m2_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							cvar_q  <= var_sat;
							state_q <= ST_NDIV;
						end
					end
				end
				ST_NDIV: begin
					if (rsp.done) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rsp.done) begin
						if (rsp.root == '0) begin
							conf_q  <= (dabs == '0) ? 17'd0 : CONF_ONE;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_CDIV;
						end
					end
				end
				ST_CDIV: begin
					if (rsp.done) begin
						conf_q  <= rsp.quo[16:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						ov_q <= 1'b1;
						if (inv_q) begin
							oc_q    <= OUT_INVALID;
							oimp_q  <= '0;
							oconf_q <= '0;
							obm_q   <= '0;
							ocm_q   <= '0;
							obv_q   <= '0;
							ocv_q   <= '0;
						end else begin
							oc_q    <= verdict;
							oimp_q  <= dsat;
							oconf_q <= conf_q;
							obm_q   <= bmean_q;
							ocm_q   <= mean_q;
							obv_q   <= bvar_q;
							ocv_q   <= cvar_q;
						end
						phase_q <= 1'b0;
						inv_q   <= 1'b0;
						bmean_q <= '0;
						bvar_q  <= '0;
						idx_q   <= '0;
						mean_q  <= '0;
						m2_q    <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall           = (state_q != ST_IDLE);
	assign cfg_ready          = 1'b1;
	assign out_valid          = ov_q;
	assign outcome            = oc_q;
	assign improvement        = oimp_q;
	assign confidence_out     = oconf_q;
	assign baseline_mean      = obm_q;
	assign candidate_mean     = ocm_q;
	assign baseline_variance  = obv_q;
	assign candidate_variance = ocv_q;
endmodule

// ===== sv/wat_checker.sv =====
// Port-level checker for the A/B trial comparator, bound to the top level.
`include "welford_ab_trial_compare_macros.svh"
module wat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  outcome,
	input logic [16:0] confidence_out,
	input logic        cfg_ready
);
	import wat_pkg::*;

	`WAT_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall, "block took a second sample without working the first")
	`WAT_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(outcome), "stalled result dropped or changed")
	`WAT_ASSERT_IMPL(a_conf_range, clk, arst_n, out_valid, confidence_out <= CONF_ONE, "confidence above one")
	`WAT_ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && outcome == OUT_INVALID, confidence_out == 17'd0, "invalid result with nonzero confidence")
	`WAT_ASSERT_IMPL(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "config port not ready")
endmodule

bind welford_ab_trial_compare wat_checker u_wat_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.outcome        (outcome),
	.confidence_out (confidence_out),
	.cfg_ready      (cfg_ready)
);

// ===== test/welford_ab_trial_compare_test.sv =====
// Testbench for the Welford A/B trial comparator: predicts verdicts and checks each result transfer.
`timescale 1ns / 1ps
module welford_ab_trial_compare_test;
	import wat_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic               bad;
	} sample_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic signed [31:0] improvement;
		logic [16:0]        confidence;
		logic signed [31:0] base_mean;
		logic signed [31:0] cand_mean;
		logic [46:0]        base_var;
		logic [46:0]        cand_var;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] sample_value = 0;
	logic sample_bad = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] outcome;
	logic signed [31:0] improvement;
	logic [16:0] confidence_out;
	logic signed [31:0] baseline_mean;
	logic signed [31:0] candidate_mean;
	logic [46:0] baseline_variance;
	logic [46:0] candidate_variance;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	welford_ab_trial_compare dut (.*);

	always #5 clk = ~clk;

	sample_t pending[$];
	verdict_t verdicts_due[$];
	int send_idle = 0;
	int recv_stall = 0;
	bit failed = 0;
	int quiet_cycles = 0;

	// predictor state
	logic [10:0] trials_reg;
	logic [30:0] margin_reg;
	logic [16:0] req_conf_reg;
	bit cand_arm;
	int unsigned count_in_arm;
	longint mean_acc;
	longint unsigned m2_acc;
	bit invalid_run;
	longint saved_mean;
	longint unsigned saved_var;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned arm_var(int unsigned n);
		longint unsigned v;
		if (n <= 1) return 0;
		v = m2_acc / (n - 1);
		return v > VAR_MAX ? VAR_MAX : v;
	endfunction

	task automatic predict_sample(sample_t s);
		int unsigned n = count_in_arm + 1;
		int unsigned eff;
		longint x = s.value;
		longint dl, dl2, d;
		longint unsigned a, b, p, cv, sum, q, r, noise, ad, conf, req;
		verdict_t v;
		if (s.bad) invalid_run = 1;
		else begin
			dl = x - mean_acc;
			mean_acc += dl / longint'(n);
			dl2 = x - mean_acc;
			a = dl < 0 ? -dl : dl;
			b = dl2 < 0 ? -dl2 : dl2;
			p = (a * b) >> 16;
			m2_acc = (m2_acc > ~64'd0 - p) ? ~64'd0 : m2_acc + p;
		end
		eff = trials_reg == 0 ? 1 : (trials_reg > MAX_TRIALS ? MAX_TRIALS : trials_reg);
		if (n < eff) begin
			count_in_arm = n;
			return;
		end
		if (!cand_arm) begin
			saved_mean = mean_acc;
			saved_var = arm_var(n);
			cand_arm = 1;
			count_in_arm = 0; mean_acc = 0; m2_acc = 0;
			return;
		end
		cv = arm_var(n);
		d = mean_acc - saved_mean;
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		sum = saved_var + cv;
		q = sum / n;
		r = sum % n;
		noise = int_sqrt((q << 16) + ((r << 16) / n));
		ad = d < 0 ? -d : d;
		if (noise == 0) conf = ad == 0 ? 0 : 65536;
		else conf = (ad << 16) / (ad + noise);
		req = req_conf_reg > CONF_ONE ? CONF_ONE : req_conf_reg;
		v = '0;
		if (!invalid_run) begin
			if (d > longint'(margin_reg) && conf >= req) v.outcome = OUT_IMPROVED;
			else if (d < -longint'(margin_reg)) v.outcome = OUT_DEGRADED;
			else v.outcome = OUT_NEUTRAL;
			v.improvement = d[31:0];
			v.confidence = conf[16:0];
			v.base_mean = saved_mean[31:0];
			v.cand_mean = mean_acc[31:0];
			v.base_var = saved_var[46:0];
			v.cand_var = cv[46:0];
		end else
			v.outcome = OUT_INVALID;
		verdicts_due.push_back(v);
		cand_arm = 0; invalid_run = 0; saved_mean = 0; saved_var = 0;
		count_in_arm = 0; mean_acc = 0; m2_acc = 0;
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) predict_sample({sample_value, sample_bad});
		if (!in_valid || !in_stall) begin
			if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
				sample_t s;
				s = pending.pop_front();
				in_valid <= 1;
				sample_value <= s.value;
				sample_bad <= s.bad;
			end else
				in_valid <= 0;
		end
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			verdict_t e;
			if (verdicts_due.size() == 0) begin
				$error("result transfer with no verdict expected");
				failed = 1;
			end else begin
				e = verdicts_due.pop_front();
				if (outcome !== e.outcome) begin
					$error("outcome exp %0d got %0d", e.outcome, outcome); failed = 1;
				end
				if (improvement !== e.improvement) begin
					$error("improvement exp %0d got %0d", e.improvement, improvement); failed = 1;
				end
				if (confidence_out !== e.confidence) begin
					$error("confidence_out exp %0d got %0d", e.confidence, confidence_out);
					failed = 1;
				end
				if (baseline_mean !== e.base_mean) begin
					$error("baseline_mean exp %0d got %0d", e.base_mean, baseline_mean); failed = 1;
				end
				if (candidate_mean !== e.cand_mean) begin
					$error("candidate_mean exp %0d got %0d", e.cand_mean, candidate_mean);
					failed = 1;
				end
				if (baseline_variance !== e.base_var) begin
					$error("baseline_variance exp %0d got %0d", e.base_var, baseline_variance);
					failed = 1;
				end
				if (candidate_variance !== e.cand_var) begin
					$error("candidate_variance exp %0d got %0d", e.cand_var, candidate_variance);
					failed = 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid
				|| (pending.size() == 0 && verdicts_due.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TRIAL_COUNT: trials_reg = val[10:0];
			CFG_MIN_IMPR:    margin_reg = val[30:0];
			CFG_REQ_CONF:    req_conf_reg = val[16:0];
			default: ;
		endcase
		cfg_valid <= 0;
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !in_valid);
		@(posedge clk);
		while (in_stall || verdicts_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic push(logic signed [31:0] v, logic b);
		sample_t s;
		s.value = v; s.bad = b;
		pending.push_back(s);
	endtask

	function automatic logic signed [31:0] rand_sample(int mode);
		case (mode)
			0: return $signed($urandom);
			1: return $signed($urandom_range(200000)) - 100000;
			default: return $signed(32'h10000 + $urandom_range(4096));
		endcase
	endfunction

	task automatic run_phase(int samples, int idle_s, int idle_r);
		int mode;
		send_idle = idle_s; recv_stall = idle_r;
		mode = $urandom_range(2);
		for (int i = 0; i < samples; i++) begin
			if ($urandom_range(15) == 0) mode = $urandom_range(2);
			push(rand_sample(mode), $urandom_range(39) == 0);
		end
		drain();
	endtask

	initial begin
		trials_reg = 16; margin_reg = 0; req_conf_reg = 0;
		cand_arm = 0; count_in_arm = 0; mean_acc = 0; m2_acc = 0;
		invalid_run = 0; saved_mean = 0; saved_var = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: one-trial runs with extremes, then a bad sample
		write_reg(CFG_TRIAL_COUNT, 1);
		push(32'sh7FFFFFFF, 0); push(-32'sh80000000, 0);
		push(-32'sh80000000, 0); push(32'sh7FFFFFFF, 0);
		push(32'sh10000, 0); push(32'sh10000, 0);
		push(32'sh10000, 1); push(32'sh0, 0);
		drain();
		write_reg(CFG_TRIAL_COUNT, 0);
		write_reg(CFG_REQ_CONF, 32'h1FFFF);
		push(32'sh20000, 0); push(32'sh30000, 0);
		push(32'sh30000, 0); push(32'sh20000, 0);
		drain();
		write_reg(CFG_TRIAL_COUNT, 3);
		write_reg(CFG_MIN_IMPR, 32'h7FFFFFFF);
		write_reg(CFG_REQ_CONF, 65536);
		push(-32'sh80000000, 0); push(32'sh7FFFFFFF, 0); push(-32'sh80000000, 0);
		push(32'sh7FFFFFFF, 0); push(-32'sh80000000, 0); push(32'sh7FFFFFFF, 1);
		drain();
		write_reg(2'd3, 32'hFFFFFFFF);
		write_reg(CFG_MIN_IMPR, 0);
		write_reg(CFG_REQ_CONF, 0);

		// random phases over several settings
		write_reg(CFG_TRIAL_COUNT, 4);
		run_phase(120, 0, 0);
		write_reg(CFG_TRIAL_COUNT, 2);
		write_reg(CFG_MIN_IMPR, $urandom_range(65536));
		run_phase(120, 73, 0);
		write_reg(CFG_TRIAL_COUNT, 5);
		write_reg(CFG_REQ_CONF, $urandom_range(65536));
		run_phase(120, 0, 73);
		write_reg(CFG_TRIAL_COUNT, 3);
		write_reg(CFG_REQ_CONF, $urandom_range(40000));
		run_phase(120, 32, 32);
		write_reg(CFG_TRIAL_COUNT, 1);
		write_reg(CFG_MIN_IMPR, 0);
		run_phase(100, 32, 73);
		write_reg(CFG_TRIAL_COUNT, 40);
		write_reg(CFG_REQ_CONF, 0);
		run_phase(80, 0, 0);
		write_reg(CFG_TRIAL_COUNT, 50);
		run_phase(100, 0, 32);
		write_reg(CFG_TRIAL_COUNT, 6);
		run_phase(60, 0, 0);

		if (failed || verdicts_due.size() != 0)
			$display("Test completed with failures");
		else
			$display("Test completed successfully");
		$finish;
	end
endmodule
